FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, sizes and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // bitmap geometry
  localparam int INODE_WORDS = 16;
  localparam int BLOCK_WORDS = 32;
  localparam int WORD_BITS   = 32;
  localparam int TOTAL_WORDS = INODE_WORDS + BLOCK_WORDS;
  localparam int MAX_WORDS   = (INODE_WORDS > BLOCK_WORDS) ? INODE_WORDS : BLOCK_WORDS;

  // derived widths
  localparam int NUM_W  = 11;
  localparam int CMP_W  = NUM_W + 1;
  localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int ADDR_W = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int OFF_W  = $clog2(MAX_WORDS + 1);
  localparam int STAT_W = 2;

  // pool sizes in entries
  localparam int INODE_ENTRIES = INODE_WORDS * WORD_BITS;
  localparam int BLOCK_ENTRIES = BLOCK_WORDS * WORD_BITS;

  // request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_BLOCK = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_FREE_RD  = 5'b00100,
    S_FREE_CHK = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over an inode use bitmap and a data block use bitmap.
// ----------------------------------------------------------------------------
// Both bitmaps live in one word memory (inode words first, then block words),
// entry k (1-based) being bit k-1 counted from the msb of word 0. An allocate
// beat scans the chosen pool one memory word per cycle through a single
// first-clear-bit finder, sets the bit and returns its number; a full pool
// answers with status 1. A free beat reads one word, checks and clears the
// bit; a zero, out-of-range or already clear number answers with status 2.
// The block takes one request at a time: an allocate occupies it until its
// scan through the memory read port finds a clear bit or reaches the last
// pool word; a free passes through read, check and done states, and a
// rejected free goes straight to done. Per-word valid flags stand for the
// cleared state after reset, so no clearing pass is needed. A finished
// response sits in an output register and does not hold up the next request.
`default_nettype none

module bitmap_block_allocator (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        req_valid,
  output logic                       req_stall,
  input  wire                        mode,
  input  wire                        pool,
  input  wire  [bba_pkg::NUM_W-1:0]  entry_number,
  output logic                       rsp_valid,
  input  wire                        rsp_stall,
  output logic [bba_pkg::NUM_W-1:0]  granted_number,
  output logic [bba_pkg::STAT_W-1:0] status
);

  bba_pkg::state_t state;

  // latched request
  logic                       pool_r;
  logic [bba_pkg::NUM_W-1:0]  num_r;

  // scan counters
  logic [bba_pkg::OFF_W-1:0]  rd_off;
  logic [bba_pkg::OFF_W-1:0]  chk_off;
  logic                       rd_pend;

  // pending result
  logic [bba_pkg::NUM_W-1:0]  res_num;
  logic [bba_pkg::STAT_W-1:0] res_status;

  // memory
  logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::TOTAL_WORDS];
  logic [bba_pkg::TOTAL_WORDS-1:0] word_valid;
  logic [bba_pkg::WORD_BITS-1:0] rdata;
  logic                          rhit;

  logic                          req_fire;
  logic                          rsp_free;
  logic                          rd_en;
  logic [bba_pkg::ADDR_W-1:0]    rd_addr;
  logic                          wr_en;
  logic [bba_pkg::ADDR_W-1:0]    wr_addr;
  logic [bba_pkg::WORD_BITS-1:0] wr_data;

  logic [bba_pkg::ADDR_W-1:0]    base;
  logic [bba_pkg::OFF_W-1:0]     words;
  logic [bba_pkg::NUM_W-1:0]     free_idx;
  logic [bba_pkg::ADDR_W-1:0]    free_word;
  logic [bba_pkg::BIT_W-1:0]     free_bit;
  logic [bba_pkg::WORD_BITS-1:0] cur_word;
  logic [bba_pkg::WORD_BITS-1:0] free_mask;
  logic [bba_pkg::WORD_BITS-1:0] find_mask;
  logic                          found;
  logic [bba_pkg::BIT_W-1:0]     find_pos;
  logic                          range_bad;
  logic [bba_pkg::CMP_W-1:0]     pool_entries;

  assign req_fire = req_valid && !req_stall;
  assign req_stall = (state != bba_pkg::S_IDLE);
  assign rsp_free = !rsp_valid || !rsp_stall;

  // pool geometry
  always_comb begin
    base  = (pool_r == bba_pkg::POOL_BLOCK) ? bba_pkg::ADDR_W'(bba_pkg::INODE_WORDS) : '0;
    words = (pool_r == bba_pkg::POOL_BLOCK) ? bba_pkg::OFF_W'(bba_pkg::BLOCK_WORDS)
                                            : bba_pkg::OFF_W'(bba_pkg::INODE_WORDS);
  end

  // range check on the incoming free number
  always_comb begin
    pool_entries = (pool == bba_pkg::POOL_BLOCK) ? bba_pkg::CMP_W'(bba_pkg::BLOCK_ENTRIES)
                                                 : bba_pkg::CMP_W'(bba_pkg::INODE_ENTRIES);
    range_bad = (entry_number == '0) || (bba_pkg::CMP_W'(entry_number) > pool_entries);
  end

  // word and bit of the number being freed
  always_comb begin
    free_idx  = num_r - bba_pkg::NUM_W'(1);
    free_word = bba_pkg::ADDR_W'(free_idx >> bba_pkg::BIT_W);
    free_bit  = free_idx[bba_pkg::BIT_W-1:0];
    free_mask = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1}
                << (bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1) - free_bit);
  end

  // word seen by the finder: never-written words read as all free
  assign cur_word = rhit ? rdata : '0;

  // first clear bit from the msb
  always_comb begin
    found    = 1'b0;
    find_pos = '0;
    for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (!cur_word[bba_pkg::WORD_BITS-1-b]) begin
        found    = 1'b1;
        find_pos = bba_pkg::BIT_W'(b);
      end
    end
    find_mask = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1}
                << (bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1) - find_pos);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base + bba_pkg::ADDR_W'(rd_off);
    wr_en   = 1'b0;
    wr_addr = base + bba_pkg::ADDR_W'(chk_off);
    wr_data = cur_word | find_mask;
    case (state)
      bba_pkg::S_SCAN: begin
        rd_en = (rd_off < words);
        wr_en = rd_pend && found;
      end
      bba_pkg::S_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = base + free_word;
      end
      bba_pkg::S_FREE_CHK: begin
        wr_en   = (cur_word & free_mask) != '0;
        wr_addr = base + free_word;
        wr_data = cur_word & ~free_mask;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // bitmap word memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // written flags and registered read hit
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rhit       <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rhit <= word_valid[rd_addr];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bba_pkg::S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        bba_pkg::S_IDLE: begin
          rd_pend <= 1'b0;
          if (req_fire) begin
            pool_r  <= pool;
            num_r   <= entry_number;
            rd_off  <= '0;
            chk_off <= '0;
            res_num <= '0;
            if (mode == bba_pkg::MODE_ALLOC) begin
              state <= bba_pkg::S_SCAN;
            end else if (range_bad) begin
              res_status <= bba_pkg::STATUS_BAD_FREE;
              state      <= bba_pkg::S_DONE;
            end else begin
              state <= bba_pkg::S_FREE_RD;
            end
          end
        end
        bba_pkg::S_SCAN: begin
          if (rd_en) begin
            rd_off <= rd_off + bba_pkg::OFF_W'(1);
          end
          rd_pend <= rd_en;
          if (rd_pend) begin
            if (found) begin
              res_num <= (bba_pkg::NUM_W'(chk_off) << bba_pkg::BIT_W)
                         + bba_pkg::NUM_W'(find_pos) + bba_pkg::NUM_W'(1);
              res_status <= bba_pkg::STATUS_OK;
              state      <= bba_pkg::S_DONE;
            end else if (chk_off == words - bba_pkg::OFF_W'(1)) begin
              res_status <= bba_pkg::STATUS_FULL;
              state      <= bba_pkg::S_DONE;
            end else begin
              chk_off <= chk_off + bba_pkg::OFF_W'(1);
            end
          end
        end
        bba_pkg::S_FREE_RD: begin
          state <= bba_pkg::S_FREE_CHK;
        end
        bba_pkg::S_FREE_CHK: begin
          res_status <= wr_en ? bba_pkg::STATUS_OK : bba_pkg::STATUS_BAD_FREE;
          state      <= bba_pkg::S_DONE;
        end
        bba_pkg::S_DONE: begin
          if (rsp_free) begin
            state <= bba_pkg::S_IDLE;
          end
        end
        default: begin
          state <= bba_pkg::S_IDLE;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= (state == bba_pkg::S_DONE);
      if (state == bba_pkg::S_DONE) begin
        granted_number <= res_num;
        status         <= res_status;
      end
    end
  end

`ifndef ASSERT_OFF
  // bitmap writes happen only while scanning or checking a free
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == bba_pkg::S_SCAN || state == bba_pkg::S_FREE_CHK))
    else $error("bitmap write outside scan or free check");

  // a bitmap write always finishes the request
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == bba_pkg::S_DONE))
    else $error("write did not finish the request");

  // failed responses carry no entry number
  a_fail_num: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == bba_pkg::STATUS_FULL || status == bba_pkg::STATUS_BAD_FREE))
    |-> (granted_number == '0))
    else $error("failed beat carries an entry number");

  // an accepted request leaves idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != bba_pkg::S_IDLE))
    else $error("sequencer stayed idle after a request beat");

  // the scan never checks past the end of the pool
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_SCAN) |-> (chk_off < words && rd_off <= words))
    else $error("scan ran past the pool");
`endif

endmodule

`default_nettype wire
